// File: rtl/core/quadrature_decoder_with_period_speed_assert.svh
// Assertion macros shared by the quadrature decoder RTL
`ifndef QUADRATURE_DECODER_WITH_PERIOD_SPEED_ASSERT_SVH
`define QUADRATURE_DECODER_WITH_PERIOD_SPEED_ASSERT_SVH

// Condition that holds at every clock edge out of reset
`define QDPS_ASSERT_HOLD(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Same-cycle implication
`define QDPS_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define QDPS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/qdps_pkg.sv
// Package: widths, codes and shared types of the quadrature decoder
`timescale 1ns / 1ps
package qdps_pkg;

  // Field widths
  localparam int ACT_W  = 2;
  localparam int MODE_W = 2;
  localparam int TC_W   = 16;
  localparam int POS_W  = 32;
  localparam int IV_W   = 32;
  localparam int TI_W   = 26;
  localparam int CPS_W  = 27;
  localparam int ADDR_W = 4;
  localparam int DATA_W = 32;

  // Speed numerator and its width
  localparam int SPEED_NUM   = 64000000;
  localparam int SPEED_NUM_W = 26;

  // Default number of overflows that mean "stopped"
  localparam int STOP_TIMEOUT_DEF = 500;

  // Reset value of the timer period register
  localparam logic [TC_W-1:0] TIMER_PERIOD_RST = 16'hFFFF;

  // Saturation bounds of the reported interval
  localparam logic signed [IV_W-1:0] TI_MAX = 32'sd33554431;
  localparam logic signed [IV_W-1:0] TI_MIN = -32'sd33554432;

  // Event codes
  localparam logic [ACT_W-1:0] ACT_EDGE_A   = 2'd0;
  localparam logic [ACT_W-1:0] ACT_EDGE_B   = 2'd1;
  localparam logic [ACT_W-1:0] ACT_OVERFLOW = 2'd2;

  // Resolution codes
  localparam logic [MODE_W-1:0] MODE_1X = 2'd0;
  localparam logic [MODE_W-1:0] MODE_2X = 2'd1;
  localparam logic [MODE_W-1:0] MODE_4X = 2'd2;

  // Register indexes
  localparam logic [1:0] REG_MODE    = 2'd0;
  localparam logic [1:0] REG_REVERSE = 2'd1;
  localparam logic [1:0] REG_PERIOD  = 2'd2;

  // Decoded edge: restart the time base, count, and count direction
  typedef struct packed {
    logic restart;
    logic count;
    logic up;
  } edge_t;

  // Divider status
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

// File: rtl/core/qdps_in_if.sv
// Event channel: valid/ready with the edge event payload
`timescale 1ns / 1ps
interface qdps_in_if;
  import qdps_pkg::*;

  logic              valid;
  logic              ready;
  logic [ACT_W-1:0]  action;
  logic              level_a;
  logic              level_b;
  logic [TC_W-1:0]   timer_count;

  modport source (output valid, action, level_a, level_b, timer_count, input ready);
  modport sink   (input valid, action, level_a, level_b, timer_count, output ready);
endinterface

// File: rtl/core/qdps_out_if.sv
// Result channel: valid/ready with position, interval and speed
`timescale 1ns / 1ps
interface qdps_out_if;
  import qdps_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [POS_W-1:0]  position;
  logic signed [TI_W-1:0]   tick_interval;
  logic signed [CPS_W-1:0]  counts_per_second;

  modport source (output valid, position, tick_interval, counts_per_second, input ready);
  modport sink   (input valid, position, tick_interval, counts_per_second, output ready);
endinterface

// File: rtl/core/qdps_dir.sv
// Quadrature edge decoder: count enable and direction per event
`timescale 1ns / 1ps
module qdps_dir (
  input  logic [qdps_pkg::ACT_W-1:0]  action,
  input  logic                        level_a,
  input  logic                        level_b,
  input  logic [qdps_pkg::MODE_W-1:0] mode,
  output qdps_pkg::edge_t             edge_info
);
  import qdps_pkg::*;

  logic wide;

  assign wide = (mode == MODE_2X) || (mode == MODE_4X);

  // Decode event against the resolution mode
  always_comb begin
    edge_info = '0;
    case (action)
      ACT_EDGE_A: begin
        edge_info.restart = 1'b1;
        if (level_a) begin
          edge_info.count = 1'b1;
          edge_info.up    = !level_b;
        end else if (wide) begin
          edge_info.count = 1'b1;
          edge_info.up    = level_b;
        end
      end
      ACT_EDGE_B: begin
        if (mode == MODE_4X) begin
          edge_info.restart = 1'b1;
          edge_info.count   = 1'b1;
          edge_info.up      = level_b ? level_a : !level_a;
        end
      end
      default: edge_info = '0;
    endcase
  end
endmodule

// File: rtl/core/qdps_div.sv
// Restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps
module qdps_div #(
  parameter int N = qdps_pkg::SPEED_NUM_W,
  parameter int D = qdps_pkg::IV_W
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [N-1:0]        dividend,
  input  logic [D-1:0]        divisor,
  output logic [N-1:0]        quotient,
  output qdps_pkg::div_stat_t stat
);
  import qdps_pkg::*;

  localparam int CW = $clog2(N + 1);

  logic [D-1:0]  rem;
  logic [N-1:0]  dq;
  logic [D-1:0]  dvs;
  logic [CW-1:0] cnt;
  logic          busy;
  logic          done;
  logic [D:0]    rem_sh;
  logic [D:0]    rem_sub;
  logic          ge;

  // Shift in next dividend bit and trial-subtract
  assign rem_sh  = {rem, dq[N-1]};
  assign rem_sub = rem_sh - {1'b0, dvs};
  assign ge      = rem_sh >= {1'b0, dvs};

  // Sequence the steps
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start && !busy) begin
        busy <= 1'b1;
        cnt  <= CW'(N);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath: remainder and dividend/quotient shift register
  always_ff @(posedge clk) begin
    if (start && !busy) begin
      rem <= '0;
      dq  <= dividend;
      dvs <= divisor;
    end else if (busy) begin
      rem <= ge ? rem_sub[D-1:0] : rem_sh[D-1:0];
      dq  <= {dq[N-2:0], ge};
    end
  end

  assign quotient  = dq;
  assign stat.busy = busy;
  assign stat.done = done;
endmodule

// File: rtl/core/quadrature_decoder_with_period_speed.sv
// Top level: quadrature decoder with interval and speed measurement
//
//  channel | dir | handshake           | word
//  evt     | in  | valid/ready         | action, level_a, level_b, timer_count
//  res     | out | valid/ready         | position, tick_interval, counts_per_second
//  apb     | in  | psel/penable/pready | resolution_mode, reverse_direction, timer_period
//
// One event word passes, after acceptance, through a multiply state (MUL), an
// update state (UPD), a divider setup state (SETUP), the divider state (DIV: 26
// quotient bits, one per cycle, and a done step) and an output state (DONE). A
// zero interval skips the divider state. A new word is taken in the cycle after
// the result loads, so no new word enters while one is still in work.
// Reset (rst, synchronous) clears position, interval, tally and capture, arms the
// re-arm flag and loads register defaults. A result waits in the output register
// while a new word is accepted; a finished word holds in DONE until it is taken.
`timescale 1ns / 1ps
module quadrature_decoder_with_period_speed #(
  parameter int STOP_TIMEOUT = qdps_pkg::STOP_TIMEOUT_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  qdps_in_if.sink                      evt,
  qdps_out_if.source                   res,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [qdps_pkg::ADDR_W-1:0]  paddr,
  input  logic [qdps_pkg::DATA_W-1:0]  pwdata,
  output logic [qdps_pkg::DATA_W-1:0]  prdata,
  output logic                         pready
);
  import qdps_pkg::*;

  `include "quadrature_decoder_with_period_speed_assert.svh"

  localparam int TW = $clog2(STOP_TIMEOUT);

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_MUL   = 6'b000010,
    ST_UPD   = 6'b000100,
    ST_SETUP = 6'b001000,
    ST_DIV   = 6'b010000,
    ST_DONE  = 6'b100000
  } state_t;

  state_t state;

  // Configuration registers
  logic [MODE_W-1:0] resolution_mode;
  logic              reverse_direction;
  logic [TC_W-1:0]   timer_period;

  // Decoder state
  logic [POS_W-1:0] position_count;
  logic [IV_W-1:0]  interval_ticks;
  logic [TW-1:0]    tally;
  logic [TC_W-1:0]  last_capture;
  logic             measure_rearm;

  // Latched event word
  logic [ACT_W-1:0] act_q;
  logic             a_q;
  logic             b_q;
  logic [TC_W-1:0]  cap_q;

  // Work registers
  logic [IV_W-1:0]  prod;
  logic             neg;
  logic [IV_W-1:0]  mag;
  logic [CPS_W-1:0] cps;

  // Output register
  logic                    out_valid;
  logic signed [POS_W-1:0] out_pos;
  logic signed [TI_W-1:0]  out_ti;
  logic signed [CPS_W-1:0] out_cps;

  edge_t                   edge_info;
  div_stat_t               div_st;
  logic [SPEED_NUM_W-1:0]  quot;
  logic                    div_start;
  logic [IV_W-1:0]         elapsed;
  logic [IV_W-1:0]         elapsed_dir;
  logic [TW:0]             tally_inc;
  logic signed [IV_W-1:0]  iv;
  logic                    cfg_wr;
  logic                    out_load;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      resolution_mode   <= MODE_1X;
      reverse_direction <= 1'b0;
      timer_period      <= TIMER_PERIOD_RST;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_MODE:    resolution_mode   <= pwdata[MODE_W-1:0];
        REG_REVERSE: reverse_direction <= pwdata[0];
        REG_PERIOD:  timer_period      <= pwdata[TC_W-1:0];
        default: ;
      endcase
    end
  end

  // Register readback
  always_comb begin
    case (paddr[3:2])
      REG_MODE:    prdata = {{(DATA_W-MODE_W){1'b0}}, resolution_mode};
      REG_REVERSE: prdata = {{(DATA_W-1){1'b0}}, reverse_direction};
      REG_PERIOD:  prdata = {{(DATA_W-TC_W){1'b0}}, timer_period};
      default:     prdata = '0;
    endcase
  end

  qdps_dir u_dir (
    .action    (act_q),
    .level_a   (a_q),
    .level_b   (b_q),
    .mode      (resolution_mode),
    .edge_info (edge_info)
  );

  qdps_div #(
    .N (SPEED_NUM_W),
    .D (IV_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (SPEED_NUM_W'(SPEED_NUM)),
    .divisor  (mag),
    .quotient (quot),
    .stat     (div_st)
  );

  assign evt.ready = (state == ST_IDLE);
  assign div_start = (state == ST_SETUP) && (mag != '0);

  // Elapsed ticks since last restart, negated for a down count
  assign elapsed     = prod + {{(IV_W-TC_W){1'b0}}, cap_q}
                     - {{(IV_W-TC_W){1'b0}}, last_capture};
  assign elapsed_dir = edge_info.up ? elapsed : (IV_W'(0) - elapsed);
  assign tally_inc   = {1'b0, tally} + 1'b1;
  assign iv          = interval_ticks;

  assign out_load = (state == ST_DONE) && (!out_valid || res.ready);

  // Sequencer and state update
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      position_count <= '0;
      interval_ticks <= '0;
      tally          <= '0;
      last_capture   <= '0;
      measure_rearm  <= 1'b1;
    end else begin
      case (state)
        ST_IDLE: begin
          if (evt.valid) begin
            state <= ST_MUL;
          end
        end
        ST_MUL: begin
          state <= ST_UPD;
        end
        ST_UPD: begin
          if (edge_info.restart) begin
            tally        <= '0;
            last_capture <= cap_q;
            if (edge_info.count) begin
              position_count <= (edge_info.up ^ reverse_direction) ?
                                position_count + 1'b1 : position_count - 1'b1;
              if (measure_rearm) begin
                measure_rearm <= 1'b0;
              end else begin
                interval_ticks <= elapsed_dir;
              end
            end
          end else if (act_q == ACT_OVERFLOW) begin
            if (tally_inc == (TW+1)'(STOP_TIMEOUT)) begin
              interval_ticks <= '0;
              tally          <= '0;
              measure_rearm  <= 1'b1;
            end else begin
              tally <= tally_inc[TW-1:0];
            end
          end
          state <= ST_SETUP;
        end
        ST_SETUP: begin
          state <= (mag != '0) ? ST_DIV : ST_DONE;
        end
        ST_DIV: begin
          if (div_st.done) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_load) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Datapath registers: event latch, product and speed
  always_ff @(posedge clk) begin
    if (evt.valid && evt.ready) begin
      act_q <= evt.action;
      a_q   <= evt.level_a;
      b_q   <= evt.level_b;
      cap_q <= evt.timer_count;
    end
    if (state == ST_MUL) begin
      prod <= {{(IV_W-TW){1'b0}}, tally} * {{(IV_W-TC_W){1'b0}}, timer_period};
    end
    if (state == ST_SETUP) begin
      if (mag == '0) begin
        cps <= '0;
      end
    end
    if (div_st.done) begin
      cps <= neg ? (CPS_W'(0) - {1'b0, quot}) : {1'b0, quot};
    end
  end

  // Divisor magnitude, taken from the updated interval
  assign mag = iv[IV_W-1] ? (IV_W'(0) - interval_ticks) : interval_ticks;

  // Quotient sign follows the interval sign, flipped when reversed
  always_ff @(posedge clk) begin
    if (state == ST_SETUP) begin
      neg <= reverse_direction ? (iv > 0) : (iv < 0);
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_pos <= position_count;
      out_cps <= cps;
      if (iv > TI_MAX) begin
        out_ti <= TI_MAX[TI_W-1:0];
      end else if (iv < TI_MIN) begin
        out_ti <= TI_MIN[TI_W-1:0];
      end else begin
        out_ti <= iv[TI_W-1:0];
      end
    end
  end

  assign res.valid             = out_valid;
  assign res.position          = out_pos;
  assign res.tick_interval     = out_ti;
  assign res.counts_per_second = out_cps;

  `QDPS_ASSERT_NEXT(a_accept_mul, evt.valid && evt.ready, state == ST_MUL, "accept did not start work")
  `QDPS_ASSERT_IMPL(a_div_done_state, div_st.done, state == ST_DIV, "divider finished outside DIV")
  `QDPS_ASSERT_HOLD(a_rearm_zero, !measure_rearm || interval_ticks == '0, "re-arm with live interval")
  `QDPS_ASSERT_HOLD(a_tally_bound, tally_inc <= (TW+1)'(STOP_TIMEOUT), "overflow tally out of range")
endmodule
